// ===== hdl/tirc_pkg.sv =====
// tirc_pkg: shared types and constants for the two-index representation block
// used by the interfaces, controller, datapath and top level
package tirc_pkg;

  localparam int ENT_W   = 18;
  localparam int ADDR_W  = 4;
  localparam int IDX_W   = 6;
  localparam int OPA_W   = 21;
  localparam int OPB_W   = 26;
  localparam int PROD_W  = OPA_W + OPB_W;
  localparam int ACC_W   = 64;
  localparam int SRC_W   = 39;
  localparam int SQ_FRAC = 24;
  localparam int LO_W    = 18;
  localparam logic [OPB_W-2:0] SQRT2_Q24 = 25'd23726566;
  localparam logic signed [ENT_W-1:0] SAT_HI = 18'sd131071;
  localparam logic signed [ENT_W-1:0] SAT_LO = -18'sd131072;
  localparam int CFG_AW = 3;

  typedef enum logic [3:0] {
    ST_LOAD, ST_RD, ST_M1, ST_M2, ST_M3, ST_M4, ST_DRAIN,
    ST_SNAP, ST_S1, ST_S2, ST_S3, ST_S4, ST_OUT
  } tirc_state_t;

  typedef enum logic [2:0] {
    MUL_XR_YR, MUL_XI_YI, MUL_XR_YI, MUL_XI_YR,
    MUL_HI_RE, MUL_LO_RE, MUL_HI_IM, MUL_LO_IM
  } mul_sel_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr_x;
    logic [ADDR_W-1:0] rd_addr_y;
    mul_sel_t          mul_sel;
    logic              acc_en;
    logic              acc_im;
    logic              acc_neg;
    logic              acc_shl;
    logic              acc_clr;
    logic              snap;
    logic              cap;
    logic              cap_scaled;
    logic              cap_last;
    logic              cap_batch;
    logic [IDX_W-1:0]  cap_index;
  } tirc_cmd_t;

  typedef struct packed {
    logic out_full;
  } tirc_stat_t;

endpackage

// ===== hdl/tirc_if.sv =====
// tirc_in_if / tirc_out_if: valid-ready channels for matrix entries and results
// depends on tirc_pkg for field widths
interface tirc_in_if;
  import tirc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ENT_W-1:0] entry_re;
  logic signed [ENT_W-1:0] entry_im;
  logic                    batch_last;
  modport source (output valid, entry_re, entry_im, batch_last, input ready);
  modport sink   (input valid, entry_re, entry_im, batch_last, output ready);
endinterface

interface tirc_out_if;
  import tirc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ENT_W-1:0] out_re;
  logic signed [ENT_W-1:0] out_im;
  logic [IDX_W-1:0]        out_index;
  logic                    out_last;
  logic                    batch_done;
  modport source (output valid, out_re, out_im, out_index, out_last, batch_done,
                  input ready);
  modport sink   (input valid, out_re, out_im, out_index, out_last, batch_done,
                  output ready);
endinterface

// ===== hdl/tirc_ctrl.sv =====
// tirc_ctrl: sequencer for loading the matrix and stepping through basis pairs
// depends on tirc_pkg; drives the datapath by command struct
module tirc_ctrl #(
  parameter int COLORS = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_batch_last,
  output logic                in_ready,
  input  logic                rep_mode,
  input  tirc_pkg::tirc_stat_t stat,
  output tirc_pkg::tirc_cmd_t  cmd
);
  import tirc_pkg::*;

  localparam int NE = COLORS * COLORS;
  localparam int AW = $clog2(NE);
  localparam int CW = $clog2(COLORS);
  localparam logic [CW-1:0] CMAX = CW'(COLORS - 1);

  tirc_state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic batch_r, batch_nxt, sym_r, sym_nxt, term_r, term_nxt, scaled_r, scaled_nxt;
  logic [CW-1:0] ri_r, ri_nxt, rj_r, rj_nxt, ci_r, ci_nxt, cj_r, cj_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic need_p2, scale, tn, row_end, col_end, last_row, last_col;
  logic [CW-1:0] i0;

  function automatic logic [ADDR_W-1:0] addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    logic [AW-1:0] a;
    a = AW'(r) * AW'(COLORS) + AW'(c);
    return ADDR_W'(a);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      cnt_r    <= '0;
      batch_r  <= 1'b0;
      sym_r    <= 1'b0;
      term_r   <= 1'b0;
      scaled_r <= 1'b0;
      ri_r <= '0; rj_r <= '0; ci_r <= '0; cj_r <= '0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      batch_r  <= batch_nxt;
      sym_r    <= sym_nxt;
      term_r   <= term_nxt;
      scaled_r <= scaled_nxt;
      ri_r <= ri_nxt; rj_r <= rj_nxt; ci_r <= ci_nxt; cj_r <= cj_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_comb begin
    need_p2  = !sym_r || ((ri_r != rj_r) && (ci_r != cj_r));
    scale    = sym_r && ((ri_r == rj_r) != (ci_r == cj_r));
    tn       = term_r && !sym_r;
    // last column of a pair row: j reaches i (symmetric) or i-1
    row_end  = sym_r ? (rj_r == ri_r) : (rj_r == ri_r - CW'(1));
    col_end  = sym_r ? (cj_r == ci_r) : (cj_r == ci_r - CW'(1));
    last_row = row_end && (ri_r == CMAX);
    last_col = col_end && (ci_r == CMAX);
    i0       = rep_mode ? '0 : CW'(1);

    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    batch_nxt  = batch_r;
    sym_nxt    = sym_r;
    term_nxt   = term_r;
    scaled_nxt = scaled_r;
    ri_nxt = ri_r; rj_nxt = rj_r; ci_nxt = ci_r; cj_nxt = cj_r;
    idx_nxt    = idx_r;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.mul_sel = MUL_XR_YR;

    case (state_r)
      ST_LOAD: begin
        in_ready    = 1'b1;
        cmd.wr_addr = ADDR_W'(cnt_r);
        if (in_valid) begin
          cmd.wr_en = 1'b1;
          batch_nxt = batch_r | in_batch_last;
          if (cnt_r == AW'(NE - 1)) begin
            cnt_nxt   = '0;
            sym_nxt   = rep_mode;
            ri_nxt = i0; rj_nxt = '0; ci_nxt = i0; cj_nxt = '0;
            idx_nxt   = '0;
            state_nxt = ST_RD;
          end else begin
            cnt_nxt = cnt_r + AW'(1);
          end
        end
      end
      ST_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_x = addr(ri_r, ci_r);
        cmd.rd_addr_y = addr(rj_r, cj_r);
        cmd.acc_clr   = 1'b1;
        term_nxt      = 1'b0;
        scaled_nxt    = 1'b0;
        state_nxt     = ST_M1;
      end
      ST_M1: begin
        cmd.mul_sel = MUL_XR_YR; cmd.acc_en = 1'b1; cmd.acc_neg = tn;
        state_nxt = ST_M2;
      end
      ST_M2: begin
        cmd.mul_sel = MUL_XI_YI; cmd.acc_en = 1'b1; cmd.acc_neg = !tn;
        state_nxt = ST_M3;
      end
      ST_M3: begin
        cmd.mul_sel = MUL_XR_YI; cmd.acc_en = 1'b1; cmd.acc_im = 1'b1; cmd.acc_neg = tn;
        state_nxt = ST_M4;
      end
      ST_M4: begin
        cmd.mul_sel = MUL_XI_YR; cmd.acc_en = 1'b1; cmd.acc_im = 1'b1; cmd.acc_neg = tn;
        if (!term_r && need_p2) begin
          // second product U_il*U_jk, read overlaps the last multiply
          cmd.rd_en     = 1'b1;
          cmd.rd_addr_x = addr(ri_r, cj_r);
          cmd.rd_addr_y = addr(rj_r, ci_r);
          term_nxt      = 1'b1;
          state_nxt     = ST_M1;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = (scale && !scaled_r) ? ST_SNAP : ST_OUT;
      end
      ST_SNAP: begin
        cmd.snap  = 1'b1;
        state_nxt = ST_S1;
      end
      ST_S1: begin
        cmd.mul_sel = MUL_HI_RE; cmd.acc_en = 1'b1; cmd.acc_shl = 1'b1;
        state_nxt = ST_S2;
      end
      ST_S2: begin
        cmd.mul_sel = MUL_LO_RE; cmd.acc_en = 1'b1;
        state_nxt = ST_S3;
      end
      ST_S3: begin
        cmd.mul_sel = MUL_HI_IM; cmd.acc_en = 1'b1; cmd.acc_im = 1'b1; cmd.acc_shl = 1'b1;
        state_nxt = ST_S4;
      end
      ST_S4: begin
        cmd.mul_sel = MUL_LO_IM; cmd.acc_en = 1'b1; cmd.acc_im = 1'b1;
        scaled_nxt = 1'b1;
        state_nxt  = ST_DRAIN;
      end
      ST_OUT: begin
        cmd.cap_scaled = scaled_r;
        cmd.cap_last   = last_row && last_col;
        cmd.cap_batch  = last_row && last_col && batch_r;
        cmd.cap_index  = idx_r;
        if (!stat.out_full) begin
          cmd.cap   = 1'b1;
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_RD;
          if (last_col) begin
            ci_nxt = sym_r ? '0 : CW'(1);
            cj_nxt = '0;
            if (last_row) begin
              batch_nxt = 1'b0;
              state_nxt = ST_LOAD;
            end else if (row_end) begin
              ri_nxt = ri_r + CW'(1);
              rj_nxt = '0;
            end else begin
              rj_nxt = rj_r + CW'(1);
            end
          end else if (col_end) begin
            ci_nxt = ci_r + CW'(1);
            cj_nxt = '0;
          end else begin
            cj_nxt = cj_r + CW'(1);
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

endmodule

// ===== hdl/tirc_dp.sv =====
// tirc_dp: matrix store, shared 21x26 multiplier, accumulators, rounding and
// output register; depends on tirc_pkg, controlled by tirc_ctrl
module tirc_dp #(
  parameter int COLORS    = 3,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tirc_pkg::tirc_cmd_t        cmd,
  output tirc_pkg::tirc_stat_t       stat,
  input  logic signed [tirc_pkg::ENT_W-1:0] in_re,
  input  logic signed [tirc_pkg::ENT_W-1:0] in_im,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic signed [tirc_pkg::ENT_W-1:0] out_re,
  output logic signed [tirc_pkg::ENT_W-1:0] out_im,
  output logic [tirc_pkg::IDX_W-1:0] out_index,
  output logic                       out_last,
  output logic                       batch_done
);
  import tirc_pkg::*;

  localparam int NE = COLORS * COLORS;
  localparam int AW = $clog2(NE);
  localparam logic signed [ACC_W-1:0] HALF_P = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] HALF_S = ACC_W'(1) <<< (FRAC_BITS + SQ_FRAC - 1);

  logic [2*ENT_W-1:0] mem [NE];
  logic [2*ENT_W-1:0] x_r, y_r;
  logic signed [OPA_W-1:0] op_a;
  logic signed [OPB_W-1:0] op_b;
  logic signed [PROD_W-1:0] prod_r;
  logic acc_en_r, acc_sel_im_r, acc_neg_r, acc_shl_r;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r, term, acc_sel, acc_sum;
  logic [SRC_W-1:0] src_re_r, src_im_r;
  logic signed [ACC_W-1:0] rnd_re, rnd_im;
  logic signed [ENT_W-1:0] sat_re, sat_im;
  logic out_valid_r;
  logic signed [ENT_W-1:0] out_re_r, out_im_r;
  logic [IDX_W-1:0] out_index_r;
  logic out_last_r, batch_done_r;

  function automatic logic signed [ENT_W-1:0] sat(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(SAT_HI)) return SAT_HI;
    else if (v < ACC_W'(SAT_LO)) return SAT_LO;
    else return v[ENT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[cmd.wr_addr[AW-1:0]] <= {in_im, in_re};
    if (cmd.rd_en) begin
      x_r <= mem[cmd.rd_addr_x[AW-1:0]];
      y_r <= mem[cmd.rd_addr_y[AW-1:0]];
    end
  end

  always_comb begin
    op_b = {{(OPB_W-ENT_W){y_r[ENT_W-1]}}, y_r[ENT_W-1:0]};
    case (cmd.mul_sel)
      MUL_XR_YR: op_a = OPA_W'(signed'(x_r[ENT_W-1:0]));
      MUL_XI_YI: begin
        op_a = OPA_W'(signed'(x_r[2*ENT_W-1:ENT_W]));
        op_b = OPB_W'(signed'(y_r[2*ENT_W-1:ENT_W]));
      end
      MUL_XR_YI: begin
        op_a = OPA_W'(signed'(x_r[ENT_W-1:0]));
        op_b = OPB_W'(signed'(y_r[2*ENT_W-1:ENT_W]));
      end
      MUL_XI_YR: op_a = OPA_W'(signed'(x_r[2*ENT_W-1:ENT_W]));
      // scaling splits the accumulated value into a signed high and unsigned low part
      MUL_HI_RE: begin op_a = src_re_r[SRC_W-1:LO_W]; op_b = {1'b0, SQRT2_Q24}; end
      MUL_LO_RE: begin op_a = OPA_W'(src_re_r[LO_W-1:0]); op_b = {1'b0, SQRT2_Q24}; end
      MUL_HI_IM: begin op_a = src_im_r[SRC_W-1:LO_W]; op_b = {1'b0, SQRT2_Q24}; end
      MUL_LO_IM: begin op_a = OPA_W'(src_im_r[LO_W-1:0]); op_b = {1'b0, SQRT2_Q24}; end
      default:   op_a = '0;
    endcase
  end

  // accumulate stage runs in the cycle after the multiply command, on the registered product
  always_comb begin
    term = ACC_W'(prod_r);
    if (acc_shl_r) term = term <<< LO_W;
    acc_sel = acc_sel_im_r ? acc_im_r : acc_re_r;
    acc_sum = acc_neg_r ? acc_sel - term : acc_sel + term;
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (!rst_n) begin
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= cmd.acc_en;
    end
    acc_sel_im_r <= cmd.acc_im;
    acc_neg_r    <= cmd.acc_neg;
    acc_shl_r    <= cmd.acc_shl;
    if (cmd.snap) begin
      src_re_r <= acc_re_r[SRC_W-1:0];
      src_im_r <= acc_im_r[SRC_W-1:0];
    end
    if (cmd.acc_clr || cmd.snap) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (acc_en_r) begin
      if (acc_sel_im_r) acc_im_r <= acc_sum;
      else              acc_re_r <= acc_sum;
    end
  end

  always_comb begin
    rnd_re = cmd.cap_scaled ? (acc_re_r + HALF_S) >>> (FRAC_BITS + SQ_FRAC)
                            : (acc_re_r + HALF_P) >>> FRAC_BITS;
    rnd_im = cmd.cap_scaled ? (acc_im_r + HALF_S) >>> (FRAC_BITS + SQ_FRAC)
                            : (acc_im_r + HALF_P) >>> FRAC_BITS;
    sat_re = sat(rnd_re);
    sat_im = sat(rnd_im);
    stat.out_full = out_valid_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.cap) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.cap) begin
      out_re_r     <= sat_re;
      out_im_r     <= sat_im;
      out_index_r  <= cmd.cap_index;
      out_last_r   <= cmd.cap_last;
      batch_done_r <= cmd.cap_batch;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_re     = out_re_r;
  assign out_im     = out_im_r;
  assign out_index  = out_index_r;
  assign out_last   = out_last_r;
  assign batch_done = batch_done_r;

endmodule

// ===== hdl/two_index_rep_of_complex_matrix.sv =====
// two_index_rep_of_complex_matrix: top level, configuration register and
// instances of tirc_ctrl and tirc_dp; depends on tirc_pkg and tirc_if
//
//  channel | direction | contents
//  in_if   | sink      | entry_re, entry_im, batch_last, one matrix entry per request
//  out_if  | source    | out_re, out_im, out_index, out_last, batch_done
//  apb     | slave     | rep_mode at byte address 0
//
// loading accepts one entry per cycle; after the last entry each result is formed
// from one product, two products or a sqrt2-scaled product, computed in sequence
// on the single shared 21x26 multiplier and its accumulate stage
// no entry is accepted while a matrix is being emitted; a stalled output
// holds the sequencer only once the next result is ready
// synchronous active-low reset clears control state and rep_mode
module two_index_rep_of_complex_matrix #(
  parameter int COLORS    = 3,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  tirc_in_if.sink    in_if,
  tirc_out_if.source out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tirc_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import tirc_pkg::*;

  logic rep_mode_r, rep_mode_nxt;
  tirc_cmd_t  cmd;
  tirc_stat_t stat;

  always_comb begin
    rep_mode_nxt = rep_mode_r;
    if (psel && penable && pwrite && !paddr[CFG_AW-1]) rep_mode_nxt = pwdata[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rep_mode_r <= 1'b0;
    else        rep_mode_r <= rep_mode_nxt;
  end

  assign pready = 1'b1;
  assign prdata = paddr[CFG_AW-1] ? 32'd0 : {31'd0, rep_mode_r};

  tirc_ctrl #(.COLORS(COLORS)) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_if.valid),
    .in_batch_last (in_if.batch_last),
    .in_ready      (in_if.ready),
    .rep_mode      (rep_mode_r),
    .stat          (stat),
    .cmd           (cmd)
  );

  tirc_dp #(.COLORS(COLORS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_re      (in_if.entry_re),
    .in_im      (in_if.entry_im),
    .out_ready  (out_if.ready),
    .out_valid  (out_if.valid),
    .out_re     (out_if.out_re),
    .out_im     (out_if.out_im),
    .out_index  (out_if.out_index),
    .out_last   (out_if.out_last),
    .batch_done (out_if.batch_done)
  );

endmodule

// ===== hdl/tirc_chk.sv =====
// tirc_chk: port-level checks on the two-index representation block
// bound to two_index_rep_of_complex_matrix; depends on tirc_pkg
module tirc_chk (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic batch_done,
  input logic [tirc_pkg::IDX_W-1:0] out_index
);
  import tirc_pkg::*;

  // a stalled result keeps its place
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_index))
    else $error("result dropped or changed while stalled");

  a_batch_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && batch_done |-> out_last)
    else $error("batch end flagged on a non-final entry");

  // no new entry is taken in the middle of a matrix emission
  a_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("entry accepted during emission");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind two_index_rep_of_complex_matrix tirc_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_last   (out_if.out_last),
  .batch_done (out_if.batch_done),
  .out_index  (out_if.out_index)
);

// ===== test/tirc_check.sv =====
// tirc_check: watches the entry and result channels of the two-index block,
// predicts each result from the loaded matrix and compares; needs tirc_pkg, tirc_if
module tirc_check #(
  parameter int COLORS    = 3,
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  tirc_in_if         in_if,
  tirc_out_if        out_if,
  input  logic       mode_sym,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tirc_pkg::*;

  localparam int ENTRIES = COLORS * COLORS;

  typedef struct packed {
    logic signed [ENT_W-1:0] re;
    logic signed [ENT_W-1:0] im;
    logic [IDX_W-1:0]        index;
    logic                    last;
    logic                    done;
  } rep_entry_t;

  rep_entry_t rep_queue[$];
  logic signed [ENT_W-1:0] link_re[ENTRIES];
  logic signed [ENT_W-1:0] link_im[ENTRIES];
  int  load_pos;
  logic batch_seen;

  assign pending = rep_queue.size();

  function automatic logic signed [ENT_W-1:0] round_clip(longint v, int sh);
    longint r;
    r = (v + (longint'(1) << (sh - 1))) >>> sh;
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[ENT_W-1:0];
  endfunction

  task automatic cmul(int a, int b, int c, int d, output longint pr, output longint pim);
    longint xr, xi, yr, yi;
    xr = link_re[a*COLORS+b]; xi = link_im[a*COLORS+b];
    yr = link_re[c*COLORS+d]; yi = link_im[c*COLORS+d];
    pr  = xr*yr - xi*yi;
    pim = xr*yi + xi*yr;
  endtask

  task automatic build_rep(logic sym);
    int pi[$], pj[$];
    int dim, a, b, k, l, sh;
    longint p1r, p1i, p2r, p2i, vr, vi;
    rep_entry_t e;
    for (int i = 0; i < COLORS; i++)
      for (int j = 0; j < COLORS; j++)
        if (j < i || (sym && j == i)) begin
          pi.push_back(i);
          pj.push_back(j);
        end
    dim = pi.size();
    for (int r = 0; r < dim; r++) begin
      for (int c = 0; c < dim; c++) begin
        a = pi[r]; b = pj[r]; k = pi[c]; l = pj[c];
        sh = FRAC_BITS;
        cmul(a, k, b, l, p1r, p1i);
        cmul(a, l, b, k, p2r, p2i);
        if (!sym) begin
          vr = p1r - p2r; vi = p1i - p2i;
        end else if (a == b && k == l) begin
          vr = p1r; vi = p1i;
        end else if (a == b || k == l) begin
          vr = p1r * 23726566; vi = p1i * 23726566; sh = FRAC_BITS + 24;
        end else begin
          vr = p1r + p2r; vi = p1i + p2i;
        end
        e.re = round_clip(vr, sh);
        e.im = round_clip(vi, sh);
        e.index = IDX_W'(r*dim + c);
        e.last = (r*dim + c + 1 == dim*dim);
        e.done = e.last && batch_seen;
        rep_queue.push_back(e);
      end
    end
    batch_seen = 0;
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    rep_entry_t w;
    if (!rst_n) begin
      load_pos <= 0;
      batch_seen = 0;
      fail_count = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        link_re[load_pos] = in_if.entry_re;
        link_im[load_pos] = in_if.entry_im;
        batch_seen |= in_if.batch_last;
        if (load_pos == ENTRIES-1) begin
          load_pos <= 0;
          build_rep(mode_sym);
        end else begin
          load_pos <= load_pos + 1;
        end
      end
      if (out_if.valid && out_if.ready) begin
        if (rep_queue.size() == 0) begin
          report("unexpected result", out_if.out_index, -1);
        end else begin
          w = rep_queue.pop_front();
          if (out_if.out_re !== w.re) report("out_re", out_if.out_re, w.re);
          if (out_if.out_im !== w.im) report("out_im", out_if.out_im, w.im);
          if (out_if.out_index !== w.index) report("out_index", out_if.out_index, w.index);
          if (out_if.out_last !== w.last) report("out_last", out_if.out_last, w.last);
          if (out_if.batch_done !== w.done) report("batch_done", out_if.batch_done, w.done);
        end
      end
    end
  end
endmodule

// ===== test/tb_top.sv =====
// tb_top: stimulus and verdict for two_index_rep_of_complex_matrix
// depends on tirc_pkg, tirc_if and the tirc_check module
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tirc_pkg::*;

  localparam int ENTRIES = 9;

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic mode_sym = 0;
  logic quiet = 0;
  logic hold_long = 0;
  int   fail_count, pending;

  tirc_in_if  in_if();
  tirc_out_if out_if();

  two_index_rep_of_complex_matrix uut (
    .clk, .rst_n, .in_if(in_if.sink), .out_if(out_if.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  tirc_check chk (
    .clk, .rst_n, .in_if, .out_if, .mode_sym, .fail_count, .pending
  );

  always #4 clk = ~clk;

  initial begin
    #20ms;
    $display("two_index_rep_of_complex_matrix test failed");
    $finish;
  end

  // result side: random stall bursts, none in the quiet tail
  initial begin
    out_if.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_long) out_if.ready <= 0;
      else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_if.ready <= 1;
      end else out_if.ready <= 1;
    end
  end

  task automatic write_mode(logic m);
    @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= '0; pwdata <= {31'd0, m};
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    mode_sym <= m;
  endtask

  // valid stays up between back-to-back requests and drops only when idling
  task automatic send_entry(logic [17:0] re, logic [17:0] im, logic bl);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      in_if.valid <= 0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_if.valid <= 1;
    in_if.entry_re <= re;
    in_if.entry_im <= im;
    in_if.batch_last <= bl;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [17:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 18'h1ffff;
      1: return 18'h20000;
      2: return 18'h10000;
      3: return 18'h30000;
      default: return 18'($urandom);
    endcase
  endfunction

  task automatic send_matrix(int kind);
    logic bl;
    for (int e = 0; e < ENTRIES; e++) begin
      bl = (e == ENTRIES-1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0);
      case (kind)
        0: send_entry(18'h1ffff, 18'h1ffff, bl);
        1: send_entry(18'h20000, 18'h20000, bl);
        2: send_entry((e % 4 == 0) ? 18'h10000 : 18'h0, 18'h0, bl);
        3: send_entry(18'h20000, 18'h1ffff, bl);
        default: send_entry(rand_val(), rand_val(), bl);
      endcase
    end
  endtask

  task automatic drain();
    in_if.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  initial begin
    in_if.valid = 0;
    in_if.entry_re = '0;
    in_if.entry_im = '0;
    in_if.batch_last = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1;
    // directed: extremes, identity, mixed saturating extremes in both modes
    for (int k = 0; k < 4; k++) send_matrix(k);
    drain();
    write_mode(1);
    for (int k = 0; k < 4; k++) send_matrix(k);
    drain();
    // long output hold-off while entries keep coming
    fork
      begin
        hold_long = 1;
        repeat (600) @(negedge clk);
        hold_long = 0;
      end
      begin
        send_matrix(4);
        send_matrix(4);
      end
    join
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_mode(ph[0]);
      if (ph == 5) quiet = 1;
      for (int m = 0; m < 7; m++) send_matrix(4);
      drain();
    end
    if (fail_count == 0)
      $display("two_index_rep_of_complex_matrix test passed");
    else
      $display("two_index_rep_of_complex_matrix test failed");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/tirc_pkg.sv
hdl/tirc_if.sv
hdl/tirc_ctrl.sv
hdl/tirc_dp.sv
hdl/two_index_rep_of_complex_matrix.sv
hdl/tirc_chk.sv
test/tirc_check.sv
test/tb_top.sv
